>>> sv/swmm_pkg.sv
`timescale 1ns / 1ps

package swmm_pkg;

  localparam int WINDOW_MAX_DEF   = 1024;
  localparam int SAMPLE_WIDTH_DEF = 32;

  // window_length register
  localparam int WLEN_W   = 11;
  localparam int WLEN_RST = 1;

  // register map: one 32-bit register, byte addresses 4*i
  localparam int ADDR_W   = 3;
  localparam int DATA_W   = 32;
  localparam logic [0:0] REG_WINDOW_LENGTH = 1'b0;

  // per-cycle control for one row of queue cells
  typedef struct packed {
    logic load;    // a sample beat is taken this cycle
    logic clear;   // restart: empty the queue
    logic expire;  // front entry leaves the window
  } cell_ctl_t;

endpackage

>>> sv/swmm_cell.sv
`timescale 1ns / 1ps

// One queue entry. Cells form a row, front at cell 0; on expiry every cell
// takes the post-pop entry of its right neighbour.
module swmm_cell #(
  parameter int SW       = swmm_pkg::SAMPLE_WIDTH_DEF,
  parameter int PW       = 11,
  parameter bit MAX_MODE = 1'b0
) (
  input  logic                 clk,
  input  logic                 rst,
  input  swmm_pkg::cell_ctl_t  ctl,
  input  logic signed [SW-1:0] new_key,
  input  logic [PW-1:0]        new_pos,
  input  logic                 prev_keep,
  input  logic                 nb_keep,
  input  logic                 nb_valid,
  input  logic [PW-1:0]        nb_pos,
  input  logic signed [SW-1:0] nb_key,
  output logic                 keep,
  output logic                 valid,
  output logic [PW-1:0]        pos,
  output logic signed [SW-1:0] key,
  output logic signed [SW-1:0] key_next
);

  logic                 dominated;
  logic                 self_valid;
  logic [PW-1:0]        self_pos;
  logic signed [SW-1:0] self_key;
  logic                 shift_valid;
  logic [PW-1:0]        shift_pos;
  logic signed [SW-1:0] shift_key;
  logic                 valid_next;
  logic [PW-1:0]        pos_next;

  // older equal entries stay
  assign dominated = MAX_MODE ? (key < new_key) : (key > new_key);
  assign keep      = valid && !dominated;

  // this slot after the back pops and the append
  always_comb begin
    if (keep) begin
      self_valid = 1'b1;
      self_pos   = pos;
      self_key   = key;
    end else begin
      self_valid = prev_keep;
      self_pos   = new_pos;
      self_key   = new_key;
    end
  end

  // right neighbour's slot after the back pops and the append
  always_comb begin
    if (nb_keep) begin
      shift_valid = nb_valid;
      shift_pos   = nb_pos;
      shift_key   = nb_key;
    end else begin
      shift_valid = keep;
      shift_pos   = new_pos;
      shift_key   = new_key;
    end
  end

  always_comb begin
    if (ctl.expire) begin
      valid_next = shift_valid;
      pos_next   = shift_pos;
      key_next   = shift_key;
    end else begin
      valid_next = self_valid;
      pos_next   = self_pos;
      key_next   = self_key;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      valid <= 1'b0;
    end else if (ctl.load) begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      pos <= pos_next;
      key <= key_next;
    end
  end

endmodule

>>> sv/swmm_chain.sv
`timescale 1ns / 1ps

// One monotonic queue as a row of cells. Entries are compacted towards cell 0.
module swmm_chain #(
  parameter int N        = swmm_pkg::WINDOW_MAX_DEF,
  parameter int SW       = swmm_pkg::SAMPLE_WIDTH_DEF,
  parameter int PW       = 11,
  parameter bit MAX_MODE = 1'b0
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  logic                 clear,
  input  logic signed [SW-1:0] new_key,
  input  logic [PW-1:0]        new_pos,
  input  logic [PW-1:0]        win,
  output logic signed [SW-1:0] front_next
);

  localparam int POS_MOD = 2 * N;

  logic                 keep  [N];
  logic                 valid [N];
  logic [PW-1:0]        pos   [N];
  logic signed [SW-1:0] key   [N];
  logic signed [SW-1:0] knext [N];

  swmm_pkg::cell_ctl_t ctl;
  logic [PW:0]         age_wide;
  logic [PW-1:0]       age;

  // age of the front entry, position counter wraps at 2*N
  always_comb begin
    if (new_pos >= pos[0]) begin
      age_wide = {1'b0, new_pos} - {1'b0, pos[0]};
    end else begin
      age_wide = {1'b0, new_pos} + (PW+1)'(POS_MOD) - {1'b0, pos[0]};
    end
  end
  assign age = age_wide[PW-1:0];

  // only a front that survives the back pops can expire, at most one a beat
  assign ctl.load   = load;
  assign ctl.clear  = clear;
  assign ctl.expire = keep[0] && (age >= win);

  generate
    for (genvar i = 0; i < N; i++) begin : g_cell
      logic                 prev_keep;
      logic                 nb_keep;
      logic                 nb_valid;
      logic [PW-1:0]        nb_pos;
      logic signed [SW-1:0] nb_key;

      if (i == 0) begin : g_first
        assign prev_keep = 1'b1;
      end else begin : g_inner
        assign prev_keep = keep[i-1];
      end

      if (i == N-1) begin : g_last
        assign nb_keep  = 1'b0;
        assign nb_valid = 1'b0;
        assign nb_pos   = '0;
        assign nb_key   = '0;
      end else begin : g_link
        assign nb_keep  = keep[i+1];
        assign nb_valid = valid[i+1];
        assign nb_pos   = pos[i+1];
        assign nb_key   = key[i+1];
      end

      swmm_cell #(
        .SW       (SW),
        .PW       (PW),
        .MAX_MODE (MAX_MODE)
      ) u_cell (
        .clk       (clk),
        .rst       (rst),
        .ctl       (ctl),
        .new_key   (new_key),
        .new_pos   (new_pos),
        .prev_keep (prev_keep),
        .nb_keep   (nb_keep),
        .nb_valid  (nb_valid),
        .nb_pos    (nb_pos),
        .nb_key    (nb_key),
        .keep      (keep[i]),
        .valid     (valid[i]),
        .pos       (pos[i]),
        .key       (key[i]),
        .key_next  (knext[i])
      );
    end
  endgenerate

  assign front_next = knext[0];

endmodule

>>> sv/sliding_window_min_max_core.sv
`timescale 1ns / 1ps
// Sliding-window minimum and maximum, two monotonic queues held in rows of cells.
// The result beat comes in the cycle after its sample beat is taken (result register).
// Throughput: 1 sample per cycle unless the result side stalls; every cell compares
// against the new sample in parallel and expiry is one row shift, so no pop loop exists.
// Reset (synchronous, active high): both queues empty, window_length = 1,
// position and fill counters cleared; a window_length write restarts likewise.
module sliding_window_min_max_core #(
  parameter int WINDOW_MAX   = swmm_pkg::WINDOW_MAX_DEF,
  parameter int SAMPLE_WIDTH = swmm_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // sample channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0] sample,
  // result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [SAMPLE_WIDTH-1:0] window_min,
  output logic signed [SAMPLE_WIDTH-1:0] window_max,
  // configuration port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [swmm_pkg::ADDR_W-1:0]    paddr,
  input  logic [swmm_pkg::DATA_W-1:0]    pwdata,
  output logic [swmm_pkg::DATA_W-1:0]    prdata,
  output logic                           pready
);

  // position counts modulo 2*WINDOW_MAX
  localparam int PW      = $clog2(2 * WINDOW_MAX);
  localparam int POS_MOD = 2 * WINDOW_MAX;

  logic [swmm_pkg::WLEN_W-1:0] window_length;
  logic [PW-1:0]               position;
  logic [PW-1:0]               position_next;
  logic [PW-1:0]               fill;
  logic [PW-1:0]               fill_next;
  logic [PW-1:0]               win;

  logic                        take;
  logic                        cfg_wr;
  logic                        emit;

  logic signed [SAMPLE_WIDTH-1:0] min_front_next;
  logic signed [SAMPLE_WIDTH-1:0] max_front_next;

  // ---------------------------------------------------------------------------
  // Configuration: register index is paddr[2]; anything past index 0 is ignored.
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite
                  && (paddr[2] == swmm_pkg::REG_WINDOW_LENGTH);

  always_comb begin
    if (paddr[2] == swmm_pkg::REG_WINDOW_LENGTH) begin
      prdata = swmm_pkg::DATA_W'(window_length);
    end else begin
      prdata = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= swmm_pkg::WLEN_W'(swmm_pkg::WLEN_RST);
    end else if (cfg_wr) begin
      window_length <= pwdata[swmm_pkg::WLEN_W-1:0];
    end
  end

  // effective window: zero reads as one, oversize clips to WINDOW_MAX
  always_comb begin
    if (window_length == '0) begin
      win = PW'(1);
    end else if (32'(window_length) > WINDOW_MAX) begin
      win = PW'(WINDOW_MAX);
    end else begin
      win = PW'(window_length);
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake: the result register parts the two sides; a new sample beat is
  // taken whenever the result slot is free or being drained.
  // ---------------------------------------------------------------------------
  assign in_stall = out_valid && out_stall;
  assign take     = in_valid && !in_stall;

  // ---------------------------------------------------------------------------
  // Position and fill counters
  // ---------------------------------------------------------------------------
  always_comb begin
    if (32'(position) == POS_MOD - 1) begin
      position_next = '0;
    end else begin
      position_next = position + PW'(1);
    end
    if (fill < win) begin
      fill_next = fill + PW'(1);
    end else begin
      fill_next = fill;
    end
  end

  // a result once the window has filled
  assign emit = (fill_next >= win);

  always_ff @(posedge clk) begin
    if (rst || cfg_wr) begin
      position <= '0;
      fill     <= '0;
    end else if (take) begin
      position <= position_next;
      fill     <= fill_next;
    end
  end

  // ---------------------------------------------------------------------------
  // The two queues: ascending for the minimum, descending for the maximum.
  // ---------------------------------------------------------------------------
  swmm_chain #(
    .N        (WINDOW_MAX),
    .SW       (SAMPLE_WIDTH),
    .PW       (PW),
    .MAX_MODE (1'b0)
  ) u_min_chain (
    .clk        (clk),
    .rst        (rst),
    .load       (take),
    .clear      (cfg_wr),
    .new_key    (sample),
    .new_pos    (position),
    .win        (win),
    .front_next (min_front_next)
  );

  swmm_chain #(
    .N        (WINDOW_MAX),
    .SW       (SAMPLE_WIDTH),
    .PW       (PW),
    .MAX_MODE (1'b1)
  ) u_max_chain (
    .clk        (clk),
    .rst        (rst),
    .load       (take),
    .clear      (cfg_wr),
    .new_key    (sample),
    .new_pos    (position),
    .win        (win),
    .front_next (max_front_next)
  );

  // ---------------------------------------------------------------------------
  // Result register: fronts of both queues after this beat's update.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= emit;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) begin
      window_min <= min_front_next;
      window_max <= max_front_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_min_le_max : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (window_min <= window_max))
    else $error("window minimum above window maximum");

  a_restart : assert property (@(posedge clk) disable iff (rst)
    cfg_wr |=> (fill == '0) && (position == '0))
    else $error("window_length write did not restart the stream");

  a_fill_bound : assert property (@(posedge clk) disable iff (rst)
    take |-> (fill <= win))
    else $error("fill count beyond window");

  a_no_early_result : assert property (@(posedge clk) disable iff (rst)
    (take && (fill_next < win)) |=> !out_valid || $past(in_stall))
    else $error("result before window filled");

endmodule

>>> tb/swmm_checker.sv
`timescale 1ns / 1ps
module swmm_checker #(
  parameter int WINDOW_MAX   = swmm_pkg::WINDOW_MAX_DEF,
  parameter int SAMPLE_WIDTH = swmm_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0]    sample,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic signed [SAMPLE_WIDTH-1:0]    window_min,
  input  logic signed [SAMPLE_WIDTH-1:0]    window_max,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [swmm_pkg::ADDR_W-1:0]       paddr,
  input  logic [swmm_pkg::DATA_W-1:0]       pwdata,
  input  logic [swmm_pkg::DATA_W-1:0]       prdata,
  input  logic                              pready,
  output int                                mismatches,
  output int                                pending,
  output int                                windows_checked
);

  typedef struct packed {
    logic [SAMPLE_WIDTH-1:0] lo;
    logic [SAMPLE_WIDTH-1:0] hi;
  } extremes_t;

  logic [swmm_pkg::WLEN_W-1:0]  window_length;
  logic signed [SAMPLE_WIDTH-1:0] recent_samples[$];
  extremes_t                    expected_extremes[$];

  // effective span: zero acts as one, anything past the store depth saturates
  function automatic int window_span(input logic [swmm_pkg::WLEN_W-1:0] len);
    if (len == 0) return 1;
    if (len > WINDOW_MAX) return WINDOW_MAX;
    return int'(len);
  endfunction

  task automatic flag(input string what, input logic signed [SAMPLE_WIDTH-1:0] want,
                      input logic signed [SAMPLE_WIDTH-1:0] got);
    $display("%0t ns: %s expected %0d, got %0d", $time, what, want, got);
    mismatches++;
  endtask

  task automatic predict_extremes(input logic signed [SAMPLE_WIDTH-1:0] s);
    int span;
    logic signed [SAMPLE_WIDTH-1:0] lo;
    logic signed [SAMPLE_WIDTH-1:0] hi;
    extremes_t e;
    span = window_span(window_length);
    recent_samples = {recent_samples, s};
    while (recent_samples.size() > span) recent_samples.delete(0);
    // nothing comes out until the window has filled since the last restart
    if (recent_samples.size() == span) begin
      lo = recent_samples[0];
      hi = recent_samples[0];
      foreach (recent_samples[i]) begin
        if (recent_samples[i] < lo) lo = recent_samples[i];
        if (recent_samples[i] > hi) hi = recent_samples[i];
      end
      e.lo = lo;
      e.hi = hi;
      expected_extremes = {expected_extremes, e};
    end
  endtask

  always @(posedge clk) begin
    extremes_t e;
    if (rst) begin
      window_length = swmm_pkg::WLEN_W'(swmm_pkg::WLEN_RST);
      recent_samples.delete();
      expected_extremes.delete();
      mismatches = 0;
      windows_checked = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_extremes.size() == 0) begin
          flag("unexpected beat, window_min", 'x, window_min);
        end else begin
          e = expected_extremes[0];
          expected_extremes.delete(0);
          if (window_min !== e.lo) flag("window_min", e.lo, window_min);
          if (window_max !== e.hi) flag("window_max", e.hi, window_max);
          windows_checked++;
        end
      end
      if (psel && penable && pready &&
          paddr[swmm_pkg::ADDR_W-1:2] == swmm_pkg::REG_WINDOW_LENGTH) begin
        if (pwrite) begin
          // a length write restarts the stream
          window_length = pwdata[swmm_pkg::WLEN_W-1:0];
          recent_samples.delete();
        end else if (prdata !== swmm_pkg::DATA_W'(window_length)) begin
          flag("window_length readback", swmm_pkg::DATA_W'(window_length), prdata);
        end
      end
      if (in_valid && !in_stall) predict_extremes(sample);
    end
    pending <= expected_extremes.size();
  end

endmodule

>>> tb/sliding_window_min_max_core_tb.sv
`timescale 1ns / 1ps
module sliding_window_min_max_core_tb;

  localparam int SW = swmm_pkg::SAMPLE_WIDTH_DEF;
  localparam int AW = swmm_pkg::ADDR_W;
  localparam int DW = swmm_pkg::DATA_W;

  // register index with nothing behind it; writes there must be dropped
  localparam logic [0:0] SPARE_INDEX = 1'b1;
  localparam logic [AW-1:0] ADDR_WINDOW_LENGTH = {swmm_pkg::REG_WINDOW_LENGTH, 2'b00};
  localparam logic [AW-1:0] ADDR_SPARE         = {SPARE_INDEX, 2'b00};

  logic          clk;
  logic          rst;
  logic          in_valid;
  logic          in_stall;
  logic [SW-1:0] sample;
  logic          out_valid;
  logic          out_stall;
  logic [SW-1:0] window_min;
  logic [SW-1:0] window_max;
  logic          psel;
  logic          penable;
  logic          pwrite;
  logic [AW-1:0] paddr;
  logic [DW-1:0] pwdata;
  logic [DW-1:0] prdata;
  logic          pready;

  int mismatches;
  int pending;
  int windows_checked;
  int samples_sent;
  int gap_odds;     // idle likelihood, 0..4 out of 8; 0 gives a stretch with no idling
  int walk_level;

  sliding_window_min_max_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .sample    (sample),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .window_min(window_min),
    .window_max(window_max),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  swmm_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .sample         (sample),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .window_min     (window_min),
    .window_max     (window_max),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .mismatches     (mismatches),
    .pending        (pending),
    .windows_checked(windows_checked)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Sample mix: full-range words for bit coverage, a narrow band so that
  // ties are common, the signed extremes, and a random walk whose trends
  // make the monotonic queues grow, pop from the back and expire at the front.
  function automatic logic [SW-1:0] draw_sample();
    case ($urandom_range(0, 9))
      0, 1, 2: return $urandom();
      3, 4:    return SW'(int'($urandom_range(0, 8)) - 4);
      5: begin
        case ($urandom_range(0, 3))
          0:       return {1'b1, {(SW-1){1'b0}}};
          1:       return {1'b0, {(SW-1){1'b1}}};
          2:       return '0;
          default: return '1;
        endcase
      end
      default: begin
        walk_level += int'($urandom_range(0, 2000)) - 1000;
        return SW'(walk_level);
      end
    endcase
  endfunction

  // One sample beat; waits out stalls, then maybe a burst of idle cycles.
  task automatic send_beat(input logic [SW-1:0] v);
    in_valid <= 1'b1;
    sample   <= v;
    do @(posedge clk); while (in_stall);
    samples_sent++;
    if ($urandom_range(1, 8) <= gap_odds) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  task automatic stream(input int n);
    repeat (n) send_beat(draw_sample());
  endtask

  // Idle point for register access: every window is back and a few spare
  // cycles cover samples still in flight that produce no result.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  // setup, access, then an idle step so back-to-back accesses never
  // drive the same signal twice in one step
  task automatic reg_access(input logic wr, input logic [AW-1:0] addr,
                            input logic [DW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_window(input logic [DW-1:0] len);
    drain();
    reg_access(1'b1, ADDR_WINDOW_LENGTH, len);
    reg_access(1'b0, ADDR_WINDOW_LENGTH, '0);
    gap_odds = $urandom_range(0, 4);
  endtask

  // Result side back-pressure in random bursts, matched to the sender's mood.
  initial begin
    int  run;
    logic hold;
    out_stall = 1'b0;
    run  = 0;
    hold = 1'b0;
    forever begin
      @(posedge clk);
      if (run == 0) begin
        hold = ($urandom_range(1, 8) <= gap_odds);
        run  = $urandom_range(1, 10);
      end
      out_stall <= hold;
      run--;
    end
  end

  initial begin
    logic [SW-1:0] pattern[$];
    rst          = 1'b1;
    in_valid     = 1'b0;
    sample       = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    gap_odds     = 2;
    walk_level   = 0;
    samples_sent = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset length of one: every beat is its own window; extremes and
    // alternating bit patterns, ending on a tie
    reg_access(1'b0, ADDR_WINDOW_LENGTH, '0);
    pattern = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                32'h0000_0001, 32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA};
    foreach (pattern[i]) send_beat(pattern[i]);

    // window of three: swing between the extremes, a rising run (back of the
    // max queue keeps popping), a falling run starting on a tie, then equals
    set_window(32'd3);
    pattern = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001,
                32'h0000_0002, 32'h0000_0003, 32'h0000_0004, 32'h0000_0004,
                32'h0000_0003, 32'h0000_0002, 32'h0000_0001, 32'h0000_0005,
                32'h0000_0005, 32'h0000_0005};
    foreach (pattern[i]) send_beat(pattern[i]);

    // zero length behaves as a window of one
    set_window(32'd0);
    stream(60);

    // upper data bits beyond the register width must be ignored (length 4)
    set_window(32'hFFFF_F804);
    stream(120);
    // write to an unmapped index: no restart, the stream simply continues
    drain();
    reg_access(1'b1, ADDR_SPARE, 32'd9);
    stream(120);

    // full depth and just past it: partial fills then a restart
    set_window(32'd1024);
    stream(40);
    set_window(32'd1025);
    stream(30);

    set_window(32'd2);
    stream(80);

    // register maximum saturates to full depth; long enough to fill and
    // slide, so old fronts expire on both queues
    set_window(32'd2047);
    stream(1060);

    // closing stretch with neither side idling
    set_window(32'd17);
    gap_odds = 0;
    stream(120);

    drain();
    repeat (8) @(posedge clk);

    $display("Sent %0d samples across window lengths 0 to 2047 (incl. saturation and",
             samples_sent);
    $display("an ignored unmapped write); %0d min/max windows compared.", windows_checked);
    if (mismatches == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #1_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

>>> files.f
sv/swmm_pkg.sv
sv/swmm_cell.sv
sv/swmm_chain.sv
sv/sliding_window_min_max_core.sv
tb/swmm_checker.sv
tb/sliding_window_min_max_core_tb.sv
